// ===== rtl/pcfa_pkg.sv =====
// ----------------------------------------------------------------------------
// pcfa_pkg
// Shared types and constants for the pitch-class chord fit analyzer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package pcfa_pkg;

    localparam int PITCH_CLASSES = 12;

    typedef enum logic [1:0] {
        CMD_NOTE   = 2'd0,
        CMD_SCORE  = 2'd1,
        CMD_REPORT = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_t;

    localparam logic [1:0] CFG_WSTART = 2'd0;
    localparam logic [1:0] CFG_WEND   = 2'd1;
    localparam logic [1:0] CFG_STEPS  = 2'd2;

    typedef struct packed {
        logic [1:0]  command;
        logic [23:0] note_start;
        logic [23:0] note_length;
        logic [6:0]  note_key;
        logic [11:0] chord_mask;
        logic [11:0] scale_mask;
        logic [11:0] context_id;
    } in_item_t;

    typedef struct packed {
        logic [3:0]  bin_index;
        logic [11:0] best_context;
        logic [39:0] best_error;
        logic        found;
        logic        last;
    } out_item_t;

    // classified command passed from front to back
    typedef struct packed {
        cmd_t        cmd;
        logic [24:0] ns;
        logic [24:0] ne;
        logic [3:0]  pc;
        logic [11:0] chord_mask;
        logic [11:0] scale_mask;
        logic [11:0] context_id;
    } job_t;

endpackage
`default_nettype wire

// ===== rtl/pcfa_front.sv =====
// ----------------------------------------------------------------------------
// pcfa_front
// Accepts input beats, derives pitch class and note end, and holds a
// two-entry queue of decoded jobs toward the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module pcfa_front
    import pcfa_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire in_item_t in_data,
    input  wire logic     in_valid,
    output logic          in_stall,
    output job_t          job,
    output logic          job_valid,
    input  wire logic     job_take
);

    job_t       q_reg [2];
    logic       rd_reg, wr_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;
    job_t       dec;
    logic [6:0] key_mod;

    // pitch class by repeated subtract, key below 128
    always_comb
    begin
        key_mod = in_data.note_key;
        for (int k = 0; k < 4; k++)
        begin
            if (key_mod >= 7'd48)
                key_mod = key_mod - 7'd48;
        end
        if (key_mod >= 7'd24)
            key_mod = key_mod - 7'd24;
        if (key_mod >= 7'd12)
            key_mod = key_mod - 7'd12;
        dec.cmd        = cmd_t'(in_data.command);
        dec.ns         = {1'b0, in_data.note_start};
        dec.ne         = {1'b0, in_data.note_start} + {1'b0, in_data.note_length};
        dec.pc         = key_mod[3:0];
        dec.chord_mask = in_data.chord_mask;
        dec.scale_mask = in_data.scale_mask;
        dec.context_id = in_data.context_id;
    end

    assign in_stall  = (cnt_reg == 2'd2);
    assign push      = in_valid && !in_stall;
    assign job_valid = (cnt_reg != 2'd0);
    assign pop       = job_valid && job_take;
    assign job       = q_reg[rd_reg];

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_reg] <= dec;
    end

    // queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wr_reg <= ~wr_reg;
            if (pop)
                rd_reg <= ~rd_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule
`default_nettype wire

// ===== rtl/pcfa_div.sv =====
// ----------------------------------------------------------------------------
// pcfa_div
// Restoring divider, one quotient bit a cycle: (i*span)/steps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module pcfa_div #(
    parameter int NW = 31
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [NW-1:0] num,
    input  wire logic [6:0]    den,
    output logic [NW-1:0]      quo,
    output logic               done
);

    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] q_reg;
    logic [6:0]    r_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic [7:0]    r_sh;

    assign r_sh = {r_reg, q_reg[NW-1]};
    assign quo  = q_reg;

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= num;
            r_reg <= 7'd0;
        end
        else if (busy_reg)
        begin
            if (r_sh >= {1'b0, den})
            begin
                r_reg <= 7'(r_sh - {1'b0, den});
                q_reg <= {q_reg[NW-2:0], 1'b1};
            end
            else
            begin
                r_reg <= r_sh[6:0];
                q_reg <= {q_reg[NW-2:0], 1'b0};
            end
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done     <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(NW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/pcfa_back.sv =====
// ----------------------------------------------------------------------------
// pcfa_back
// Executes jobs: bin walk with divider for notes, histogram sweep for
// scoring, per-bin report, and a clearing pass over the store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module pcfa_back
    import pcfa_pkg::*;
#(
    parameter int MAX_BINS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [23:0] window_start,
    input  wire logic [23:0] window_end,
    input  wire logic [4:0]  num_steps,
    input  wire job_t        job,
    input  wire logic        job_valid,
    output logic             job_take,
    output out_item_t        out_data,
    output logic             out_valid,
    input  wire logic        out_stall
);

    localparam int BW    = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int IW    = $clog2(MAX_BINS + 1);
    localparam int DEPTH = MAX_BINS * PITCH_CLASSES;
    localparam int AW    = $clog2(DEPTH);
    localparam int NW    = IW + 24;

    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_DIV    = 11'b00000000010,
        S_DWAIT  = 11'b00000000100,
        S_NRD    = 11'b00000001000,
        S_NWR    = 11'b00000010000,
        S_SRD    = 11'b00000100000,
        S_SACC   = 11'b00001000000,
        S_SUPD   = 11'b00010000000,
        S_REP    = 11'b00100000000,
        S_CLR    = 11'b01000000000,
        S_CLRSC  = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;

    // histogram memory, cleared by sweep on clear and after reset
    logic [31:0] hist_mem [DEPTH];
    logic [31:0] hist_rd_reg;
    logic [AW-1:0] rd_addr, wr_addr;
    logic          hist_we;
    logic [31:0]   hist_wd;

    logic [39:0] best_err_reg [MAX_BINS];
    logic [11:0] best_ctx_reg [MAX_BINS];
    logic [MAX_BINS-1:0] scored_reg;

    logic [IW-1:0] steps;
    logic [IW-1:0] bin_reg;      // current bin, boundary index
    logic [3:0]    k_reg;        // pitch class during scoring
    logic [24:0]   lo_reg, hi_reg;
    logic [41:0]   err_reg;
    logic [AW-1:0] clr_reg;
    logic          first_reg;    // lo of bin 0 not yet computed
    job_t          job_reg;
    logic [23:0]   span;
    logic          div_start, div_done;
    logic [NW-1:0] div_num, div_quo;
    logic [24:0]   bound;
    logic [BW-1:0] bin_idx;
    logic [BW-1:0] note_idx;     // bin under update, one below the boundary index
    logic [24:0]   ov_a, ov_b;
    logic [32:0]   hsum;
    logic [1:0]    miss;
    logic          out_free;

    assign steps = (num_steps == 5'd0) ? IW'(1)
                 : ({27'd0, num_steps} > 32'(MAX_BINS)) ? IW'(MAX_BINS)
                 : IW'(num_steps);
    assign span    = (window_end >= window_start) ? window_end - window_start : 24'd0;
    assign bin_idx = bin_reg[BW-1:0];
    assign note_idx = BW'(bin_reg - 1'b1);
    assign div_num = NW'(bin_reg) * NW'(span);
    assign bound   = 25'(div_quo) + {1'b0, window_start};
    assign out_free = !out_valid || !out_stall;

    assign ov_a = (job_reg.ns > lo_reg) ? job_reg.ns : lo_reg;
    assign ov_b = (job_reg.ne < hi_reg) ? job_reg.ne : hi_reg;
    assign hsum = {1'b0, hist_rd_reg} + {8'd0, ov_b - ov_a};
    assign miss = {1'b0, !job_reg.chord_mask[k_reg]} + {1'b0, !job_reg.scale_mask[k_reg]};

    pcfa_div #(.NW(NW)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   ({2'b0, steps}),
        .quo   (div_quo),
        .done  (div_done)
    );

    // memory addressing
    always_comb
    begin
        rd_addr = AW'(note_idx * PITCH_CLASSES) + AW'(job_reg.pc);
        if (state_reg == S_SRD || state_reg == S_SACC)
            rd_addr = AW'(bin_idx * PITCH_CLASSES) + AW'(k_reg);
        wr_addr = AW'(note_idx * PITCH_CLASSES) + AW'(job_reg.pc);
        hist_we = 1'b0;
        hist_wd = hsum[32] ? 32'hFFFFFFFF : hsum[31:0];
        if (state_reg == S_NWR)
            hist_we = (job_reg.ne >= lo_reg) && (job_reg.ns < hi_reg);
        if (state_reg == S_CLR)
        begin
            hist_we = 1'b1;
            wr_addr = clr_reg;
            hist_wd = 32'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (hist_we)
            hist_mem[wr_addr] <= hist_wd;
        hist_rd_reg <= hist_mem[rd_addr];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        job_take   = 1'b0;
        div_start  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (job_valid)
                begin
                    job_take = 1'b1;
                    case (job.cmd)
                        CMD_NOTE:   state_next = S_DIV;
                        CMD_SCORE:  state_next = S_SRD;
                        CMD_REPORT: state_next = S_REP;
                        CMD_CLEAR:  state_next = S_CLR;
                        default:    state_next = S_IDLE;
                    endcase
                end
            end
            S_DIV:
            begin
                div_start  = 1'b1;
                state_next = S_DWAIT;
            end
            S_DWAIT:
            begin
                if (div_done)
                    state_next = first_reg ? S_DIV : S_NRD;
            end
            S_NRD:   state_next = S_NWR;
            S_NWR:   state_next = (bin_reg == steps) ? S_IDLE : S_DIV;
            S_SRD:   state_next = S_SACC;
            S_SACC:  state_next = (k_reg == 4'(PITCH_CLASSES - 1)) ? S_SUPD : S_SRD;
            S_SUPD:  state_next = (bin_reg == steps - 1'b1) ? S_IDLE : S_SRD;
            S_REP:
            begin
                if (out_free && bin_reg == steps - 1'b1)
                    state_next = S_IDLE;
            end
            S_CLR:   state_next = (clr_reg == AW'(DEPTH - 1)) ? S_CLRSC : S_CLR;
            S_CLRSC: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // control and bin state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLR;
            bin_reg    <= '0;
            k_reg      <= '0;
            clr_reg    <= '0;
            first_reg  <= 1'b0;
            scored_reg <= '0;
            out_valid  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid <= (state_reg == S_REP && out_free) || (out_valid && out_stall);
            case (state_reg)
                S_IDLE:
                begin
                    bin_reg   <= '0;
                    k_reg     <= '0;
                    clr_reg   <= '0;
                    first_reg <= 1'b1;
                end
                S_DWAIT:
                begin
                    if (div_done)
                    begin
                        first_reg <= 1'b0;
                        if (first_reg)
                            bin_reg <= bin_reg + 1'b1;
                    end
                end
                S_NWR:   bin_reg <= bin_reg + 1'b1;
                S_SACC:  k_reg <= k_reg + 1'b1;
                S_SUPD:
                begin
                    k_reg   <= '0;
                    bin_reg <= bin_reg + 1'b1;
                    if (!scored_reg[bin_idx] || 40'(err_reg) < best_err_reg[bin_idx])
                        scored_reg[bin_idx] <= 1'b1;
                end
                S_REP:
                begin
                    if (out_free)
                        bin_reg <= bin_reg + 1'b1;
                end
                S_CLR:   clr_reg <= clr_reg + 1'b1;
                S_CLRSC: scored_reg <= '0;
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && job_valid)
            job_reg <= job;
        if (state_reg == S_SRD && k_reg == 4'd0)
            err_reg <= '0;
        if (state_reg == S_SACC)
            err_reg <= err_reg + (miss[1] ? {9'd0, hist_rd_reg, 1'b0}
                                : miss[0] ? {10'd0, hist_rd_reg} : 42'd0);
        if (state_reg == S_DWAIT && div_done)
        begin
            lo_reg <= hi_reg;
            hi_reg <= bound;
        end
        if (state_reg == S_SUPD &&
            (!scored_reg[bin_idx] || 40'(err_reg) < best_err_reg[bin_idx]))
        begin
            best_err_reg[bin_idx] <= 40'(err_reg);
            best_ctx_reg[bin_idx] <= job_reg.context_id;
        end
        if (state_reg == S_REP && out_free)
        begin
            out_data.bin_index    <= 4'(bin_reg);
            out_data.best_context <= scored_reg[bin_idx] ? best_ctx_reg[bin_idx] : 12'd0;
            out_data.best_error   <= scored_reg[bin_idx] ? best_err_reg[bin_idx] : 40'd0;
            out_data.found        <= scored_reg[bin_idx];
            out_data.last         <= (bin_reg == steps - 1'b1);
        end
    end

endmodule
`default_nettype wire

// ===== rtl/pitch_class_chord_fit_analyzer.sv =====
// Chord fit analyzer over a binned time window. A note beat runs one
// 29-bit serial divide per bin boundary plus the histogram read-modify-write
// per bin, with one more divide for the lower edge of the first bin; a score
// beat reads and accumulates each pitch class of each bin, then updates that
// bin's best if its error is lower; a report emits one bin per cycle while
// out_stall is low; and a clear walks the MAX_BINS*12 histogram entries one entry a cycle;
// the same pass runs after reset before the first beat executes. A two-deep
// queue lets input beats be taken while the back end works.
`timescale 1ns / 1ps
`default_nettype none
module pitch_class_chord_fit_analyzer
    import pcfa_pkg::*;
#(
    parameter int MAX_BINS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire in_item_t    in_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    output out_item_t        out_data,
    output logic             out_valid,
    input  wire logic        out_stall,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [23:0] cfg_data
);

    logic [23:0] wstart_reg, wend_reg;
    logic [4:0]  steps_reg;
    job_t        job;
    logic        job_valid, job_take;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wstart_reg <= '0;
            wend_reg   <= '0;
            steps_reg  <= 5'd1;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_WSTART: wstart_reg <= cfg_data;
                CFG_WEND:   wend_reg   <= cfg_data;
                CFG_STEPS:  steps_reg  <= cfg_data[4:0];
                default:    ;
            endcase
        end
    end

    pcfa_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .job       (job),
        .job_valid (job_valid),
        .job_take  (job_take)
    );

    pcfa_back #(.MAX_BINS(MAX_BINS)) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .window_start (wstart_reg),
        .window_end   (wend_reg),
        .num_steps    (steps_reg),
        .job          (job),
        .job_valid    (job_valid),
        .job_take     (job_take),
        .out_data     (out_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall)
    );

endmodule
`default_nettype wire

// ===== rtl/pcfa_checker.sv =====
// ----------------------------------------------------------------------------
// pcfa_checker
// Port-level checks on the analyzer, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module pcfa_checker
    import pcfa_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire out_item_t out_data,
    input wire logic      out_valid,
    input wire logic      out_stall,
    input wire logic      cfg_ready
);

    // stalled result beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    // unscored bin reports zeros
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.found |-> out_data.best_error == 40'd0
        && out_data.best_context == 12'd0)
        else $error("unscored bin not zero");

    // bin index advances within a report run
    a_seq: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !out_data.last ##1 out_valid
        |-> out_data.bin_index == $past(out_data.bin_index) + 4'd1)
        else $error("bin index skipped");

    // config port always open
    a_cfg: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
        else $error("config not ready");

endmodule

bind pitch_class_chord_fit_analyzer pcfa_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cfg_ready (cfg_ready)
);
`default_nettype wire

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the pitch-class chord fit analyzer. Directed and
// random note, score, report and clear beats are driven under random idling
// on both sides; a local predictor builds the expected report beats, and a
// checker compares every output beat field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb;
    import pcfa_pkg::*;

    localparam int NBINS = 16;
    localparam int NPC   = 12;

    logic        clk;
    logic        rst_n;
    in_item_t    in_data;
    logic        in_valid;
    logic        in_stall;
    out_item_t   out_data;
    logic        out_valid;
    logic        out_stall;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [23:0] cfg_data;

    pitch_class_chord_fit_analyzer u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_data  (out_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor state
    logic [23:0] win_lo;
    logic [23:0] win_hi;
    logic [4:0]  step_reg;
    logic [31:0] hist [NBINS*NPC];
    logic [39:0] best_err [NBINS];
    logic [11:0] best_ctx [NBINS];
    logic        scored [NBINS];

    out_item_t   report_q[$];
    int          errors;
    bit          calm;

    // clock
    initial clk = 1'b0;
    always #1 clk = ~clk;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("error %0t: %s got %0h want %0h", $time, what, got, want);
        errors++;
    endtask

    function automatic int active_bins();
        if (step_reg == 5'd0)
            return 1;
        if (step_reg > NBINS)
            return NBINS;
        return int'(step_reg);
    endfunction

    function automatic logic [24:0] bin_edge(input int i, input int n);
        logic [24:0] span;
        logic [31:0] prod;
        span = (win_hi >= win_lo) ? {1'b0, win_hi - win_lo} : 25'd0;
        prod = 32'(i) * 32'(span);
        return 25'(prod / 32'(n)) + {1'b0, win_lo};
    endfunction

    task automatic wipe_store();
        for (int i = 0; i < NBINS*NPC; i++)
            hist[i] = '0;
        for (int i = 0; i < NBINS; i++)
        begin
            best_err[i] = '0;
            best_ctx[i] = '0;
            scored[i]   = 1'b0;
        end
    endtask

    // model one accepted beat
    task automatic predict_beat(input in_item_t it);
        int          n;
        logic [24:0] ns, ne, lo, hi, a, b;
        logic [32:0] sum;
        logic [39:0] err;
        int          pc;
        n = active_bins();
        case (cmd_t'(it.command))
            CMD_NOTE:
            begin
                ns = {1'b0, it.note_start};
                ne = ns + {1'b0, it.note_length};
                pc = int'(it.note_key) % NPC;
                for (int i = 0; i < n; i++)
                begin
                    lo = bin_edge(i, n);
                    hi = bin_edge(i + 1, n);
                    if (ne >= lo && ns < hi)
                    begin
                        a = (ns > lo) ? ns : lo;
                        b = (ne < hi) ? ne : hi;
                        sum = {1'b0, hist[i*NPC+pc]} + 33'(b - a);
                        hist[i*NPC+pc] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                    end
                end
            end
            CMD_SCORE:
                for (int i = 0; i < n; i++)
                begin
                    err = '0;
                    for (int k = 0; k < NPC; k++)
                    begin
                        if (!it.chord_mask[k])
                            err += 40'(hist[i*NPC+k]);
                        if (!it.scale_mask[k])
                            err += 40'(hist[i*NPC+k]);
                    end
                    if (!scored[i] || err < best_err[i])
                    begin
                        scored[i]   = 1'b1;
                        best_err[i] = err;
                        best_ctx[i] = it.context_id;
                    end
                end
            CMD_REPORT:
                for (int i = 0; i < n; i++)
                    report_q.push_back('{bin_index: 4'(i),
                        best_context: scored[i] ? best_ctx[i] : 12'd0,
                        best_error: scored[i] ? best_err[i] : 40'd0,
                        found: scored[i], last: (i == n - 1)});
            default:
                wipe_store();
        endcase
    endtask

    task automatic idle_burst();
        repeat ($urandom_range(1, 14)) @(negedge clk);
    endtask

    // send one beat, predict at acceptance
    task automatic send_beat(input in_item_t it);
        if (!calm && $urandom_range(0, 5) == 0)
            idle_burst();
        in_data  = it;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        predict_beat(it);
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
        cfg_index = idx;
        cfg_data  = val;
        cfg_valid = 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_WSTART: win_lo   = val;
            CFG_WEND:   win_hi   = val;
            default:    step_reg = val[4:0];
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // wait out queued results, then idle long enough for the back end to finish the beats it still holds
    task automatic drain();
        while (report_q.size() != 0)
            @(negedge clk);
        repeat (2400) @(negedge clk);
    endtask

    task automatic set_window(input logic [23:0] lo, input logic [23:0] hi,
                              input logic [4:0] n);
        drain();
        write_reg(CFG_WSTART, lo);
        write_reg(CFG_WEND, hi);
        write_reg(CFG_STEPS, n);
    endtask

    function automatic in_item_t note_beat(input logic [23:0] st,
                                           input logic [23:0] len,
                                           input logic [6:0] key);
        in_item_t it;
        it = in_item_t'({$urandom, $urandom, $urandom});
        it.command     = CMD_NOTE;
        it.note_start  = st;
        it.note_length = len;
        it.note_key    = key;
        return it;
    endfunction

    function automatic in_item_t score_beat(input logic [11:0] ch,
                                            input logic [11:0] sc,
                                            input logic [11:0] id);
        in_item_t it;
        it = in_item_t'({$urandom, $urandom, $urandom});
        it.command    = CMD_SCORE;
        it.chord_mask = ch;
        it.scale_mask = sc;
        it.context_id = id;
        return it;
    endfunction

    function automatic in_item_t cmd_beat(input cmd_t c);
        in_item_t it;
        it = in_item_t'({$urandom, $urandom, $urandom});
        it.command = c;
        return it;
    endfunction

    // directed: extremes, every command, ties, empty report
    task automatic test_directed();
        send_beat(cmd_beat(CMD_REPORT));
        send_beat(note_beat(24'd0, 24'd0, 7'd0));
        send_beat(score_beat(12'h000, 12'hFFF, 12'hFFF));
        send_beat(cmd_beat(CMD_REPORT));
        set_window(24'd100, 24'd1100, 5'd4);
        send_beat(note_beat(24'd0, 24'hFFFFFF, 7'd127));
        send_beat(note_beat(24'd350, 24'd0, 7'd60));
        send_beat(note_beat(24'd600, 24'd500, 7'd11));
        send_beat(note_beat(24'hFFFFFF, 24'hFFFFFF, 7'd12));
        send_beat(score_beat(12'hFFF, 12'hFFF, 12'd5));
        send_beat(score_beat(12'hFFF, 12'hFFF, 12'd6));
        send_beat(score_beat(12'h000, 12'h000, 12'd7));
        send_beat(cmd_beat(CMD_REPORT));
        send_beat(cmd_beat(CMD_CLEAR));
        send_beat(cmd_beat(CMD_REPORT));
        // reversed window, zero and oversize step counts
        set_window(24'd5000, 24'd10, 5'd0);
        send_beat(note_beat(24'd0, 24'd9000, 7'd3));
        send_beat(score_beat(12'h0F0, 12'h00F, 12'd9));
        send_beat(cmd_beat(CMD_REPORT));
        set_window(24'd0, 24'hFFFFFF, 5'd31);
        send_beat(note_beat(24'd0, 24'hFFFFFF, 7'd64));
        send_beat(score_beat(12'h000, 12'h000, 12'hABC));
        send_beat(cmd_beat(CMD_REPORT));
    endtask

    // saturation: repeated full-window notes on one class
    task automatic test_saturation();
        set_window(24'd0, 24'hFFFFFF, 5'd1);
        send_beat(cmd_beat(CMD_CLEAR));
        repeat (260)
            send_beat(note_beat(24'd0, 24'hFFFFFF, 7'd7));
        send_beat(score_beat(12'h000, 12'h000, 12'd1));
        send_beat(cmd_beat(CMD_REPORT));
    endtask

    // random phases: optional clear, notes, contexts, an occasional random beat, then a report
    task automatic test_random(input int phases);
        logic [23:0] lo, len;
        for (int p = 0; p < phases; p++)
        begin
            lo  = $urandom_range(0, 3) == 0 ? 24'($urandom) : 24'($urandom_range(0, 2000));
            len = $urandom_range(0, 3) == 0 ? 24'($urandom) : 24'($urandom_range(0, 5000));
            if (p % 6 == 5)
                set_window(lo + len, lo, 5'($urandom));
            else
                set_window(lo, lo + len, 5'($urandom_range(1, 16)));
            if ($urandom_range(0, 2) == 0)
                send_beat(cmd_beat(CMD_CLEAR));
            if (p >= phases - 3)
                calm = 1'b1;
            repeat ($urandom_range(2, 8))
                send_beat(note_beat(
                    $urandom_range(0, 7) == 0 ? 24'($urandom)
                                              : lo + 24'($urandom_range(0, 5000)) - 24'd200,
                    $urandom_range(0, 7) == 0 ? 24'($urandom)
                                              : 24'($urandom_range(0, 3000)),
                    7'($urandom)));
            repeat ($urandom_range(1, 4))
                send_beat(score_beat(12'($urandom), 12'($urandom),
                                     12'($urandom_range(0, 3) == 0 ? 1 : $urandom)));
            if ($urandom_range(0, 9) == 0)
                send_beat(in_item_t'({$urandom, $urandom, $urandom}));
            send_beat(cmd_beat(CMD_REPORT));
        end
    endtask

    // receiver stall pattern
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!calm && $urandom_range(0, 15) == 0)
            begin
                out_stall <= 1'b1;
                idle_burst();
                out_stall <= 1'b0;
            end
        end
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (report_q.size() == 0)
                report_mismatch("unexpected result", 64'(out_data), 64'd0);
            else
            begin
                out_item_t want;
                want = report_q.pop_front();
                if (out_data.bin_index !== want.bin_index)
                    report_mismatch("bin_index", 64'(out_data.bin_index), 64'(want.bin_index));
                if (out_data.best_context !== want.best_context)
                    report_mismatch("best_context", 64'(out_data.best_context),
                                    64'(want.best_context));
                if (out_data.best_error !== want.best_error)
                    report_mismatch("best_error", 64'(out_data.best_error),
                                    64'(want.best_error));
                if (out_data.found !== want.found)
                    report_mismatch("found", 64'(out_data.found), 64'(want.found));
                if (out_data.last !== want.last)
                    report_mismatch("last", 64'(out_data.last), 64'(want.last));
            end
        end
    end

    // main sequence
    initial
    begin
        errors    = 0;
        calm      = 1'b0;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_WSTART;
        cfg_data  = '0;
        win_lo    = '0;
        win_hi    = '0;
        step_reg  = 5'd1;
        wipe_store();
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_saturation();
        test_random(10);
        while (report_q.size() != 0)
            @(negedge clk);
        repeat (2400) @(negedge clk);
        if (errors == 0)
            $display("pitch_class_chord_fit_analyzer: match");
        else
            $display("pitch_class_chord_fit_analyzer: mismatch");
        $finish;
    end

    // watchdog
    initial
    begin
        #4000000;
        $display("pitch_class_chord_fit_analyzer: mismatch");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/pcfa_pkg.sv
rtl/pcfa_front.sv
rtl/pcfa_div.sv
rtl/pcfa_back.sv
rtl/pitch_class_chord_fit_analyzer.sv
rtl/pcfa_checker.sv
dv/tb.sv
